/* rtl/cksa_pkg.sv */
// Shared types and constants for the chroma key soft alpha block.
// No dependencies; every other file of the block imports this package.
package cksa_pkg;

  // Channel width of one colour component, and the width of the ramp numerator.
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned NUM_W     = 2 * PIX_W;
  // One restoring division cell per quotient bit.
  localparam int unsigned NUM_CELLS = PIX_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [PIX_W-1:0] KEY_RED_RST   = 8'd0;
  localparam logic [PIX_W-1:0] KEY_GREEN_RST = 8'd255;
  localparam logic [PIX_W-1:0] KEY_BLUE_RST  = 8'd0;
  localparam logic [PIX_W-1:0] TOL_RST       = 8'd0;
  localparam logic [PIX_W-1:0] SOFT_RST      = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_RED   = 3'd0,
    REG_KEY_GREEN = 3'd1,
    REG_KEY_BLUE  = 3'd2,
    REG_TOLERANCE = 3'd3,
    REG_SOFTNESS  = 3'd4
  } cfg_reg_e;

  // How the alpha of an item is to be formed at the end of the chain.
  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_PASS  = 2'd1,
    MODE_RAMP  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [PIX_W-1:0] key_red;
    logic [PIX_W-1:0] key_green;
    logic [PIX_W-1:0] key_blue;
    logic [PIX_W-1:0] tolerance;
    logic [PIX_W-1:0] softness;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic             last;
  } pix_t;

  // What travels from cell to cell: the pixel, its mode, the partial
  // remainder and a word that holds the unused numerator bits at the top
  // and the quotient bits found so far at the bottom.
  typedef struct packed {
    pix_t             pix;
    mode_e            mode;
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] lowq;
  } div_t;

endpackage

/* rtl/cksa_front.sv */
// Front end of the keyer: colour distance, classification and ramp numerator.
// Two register stages; depends on cksa_pkg.
module cksa_front
  import cksa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  pix_t  pix_i,
  input  cfg_t  cfg_i,
  output logic  valid_o,
  output div_t  data_o
);

  logic [PIX_W-1:0] diff_r, diff_g, diff_b, dist_rg, dist_max;
  logic [PIX_W:0]   ramp_end;
  mode_e            mode_d;
  logic [PIX_W-1:0] edge_d;
  logic [NUM_W-1:0] num_d;

  logic             s1_valid_q;
  pix_t             s1_pix_q;
  mode_e            s1_mode_q;
  logic [PIX_W-1:0] s1_edge_q;

  logic             valid_q;
  div_t             data_q;

  always_comb begin
    diff_r = (pix_i.red > cfg_i.key_red) ? pix_i.red - cfg_i.key_red
                                         : cfg_i.key_red - pix_i.red;
    diff_g = (pix_i.green > cfg_i.key_green) ? pix_i.green - cfg_i.key_green
                                             : cfg_i.key_green - pix_i.green;
    diff_b = (pix_i.blue > cfg_i.key_blue) ? pix_i.blue - cfg_i.key_blue
                                           : cfg_i.key_blue - pix_i.blue;
    dist_rg  = (diff_g > diff_r) ? diff_g : diff_r;
    dist_max = (diff_b > dist_rg) ? diff_b : dist_rg;
    ramp_end = {1'b0, cfg_i.tolerance} + {1'b0, cfg_i.softness};
    edge_d   = dist_max - cfg_i.tolerance;
    if (dist_max <= cfg_i.tolerance) begin
      mode_d = MODE_CLEAR;
    end else if ((cfg_i.softness != '0) && ({1'b0, dist_max} < ramp_end)) begin
      mode_d = MODE_RAMP;
    end else begin
      mode_d = MODE_PASS;
    end
  end

  // Rounded numerator: alpha times edge plus half the softness.
  assign num_d = ({{PIX_W{1'b0}}, s1_pix_q.alpha} * {{PIX_W{1'b0}}, s1_edge_q})
               + {{(PIX_W+1){1'b0}}, cfg_i.softness[PIX_W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pix_q    <= pix_i;
      s1_mode_q   <= mode_d;
      s1_edge_q   <= edge_d;
      data_q.pix  <= s1_pix_q;
      data_q.mode <= s1_mode_q;
      data_q.rem  <= num_d[NUM_W-1:PIX_W];
      data_q.lowq <= num_d[PIX_W-1:0];
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/cksa_div_cell.sv */
// One restoring division cell: brings down one numerator bit, yields one quotient bit.
// Depends on cksa_pkg.
module cksa_div_cell
  import cksa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  div_t             data_i,
  input  logic [PIX_W-1:0] divisor_i,
  output logic             valid_o,
  output div_t             data_o
);

  logic [PIX_W:0]   trial;
  logic [PIX_W:0]   diff;
  logic             fits;
  div_t             data_d;
  logic             valid_q;
  div_t             data_q;

  always_comb begin
    trial       = {data_i.rem, data_i.lowq[PIX_W-1]};
    diff        = trial - {1'b0, divisor_i};
    fits        = (trial >= {1'b0, divisor_i});
    data_d      = data_i;
    data_d.rem  = fits ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
    data_d.lowq = {data_i.lowq[PIX_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/cksa_out.sv */
// Output register with a skid stage, decoupling the result stall from the chain.
// Depends on cksa_pkg.
module cksa_out
  import cksa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  pix_t pix_i,
  output logic en_o,
  output logic out_valid_o,
  output pix_t pix_o,
  input  logic out_stall_i
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  pix_t out_q, out_d;
  pix_t skid_q, skid_d;
  logic take;

  always_comb begin
    take         = out_valid_q && !out_stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_d = valid_i;
      if (valid_i) begin
        out_d = pix_i;
      end
    end else if (valid_i) begin
      skid_d       = pix_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign en_o        = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign pix_o       = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item while the output register is empty");

  a_skid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !take) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid item lost or changed while the output is stalled");

endmodule

/* rtl/chroma_key_soft_alpha_top.sv */
// Top level of the chroma key soft alpha block: configuration registers,
// front end, the chain of division cells and the output skid; uses cksa_pkg.

// The keyer takes one RGBA8 pixel item per clock and returns one item per
// clock while nothing stalls. An item passes eleven register stages: two
// front-end stages (colour distance, then the alpha times edge product),
// eight division cells that each settle one bit of the rounded ramp quotient,
// and the output register. The edge that accepts an item loads the first of
// them. Every cell advances together, so items follow each other back to
// back. When the result side stalls, one further item is caught in a skid
// register, after which the input side is stalled until the result side
// takes again. RGB and the end-of-image mark pass through unchanged.
// Configuration writes are always ready and take effect at once; they should
// be made only while no item is in flight.
module chroma_key_soft_alpha_top
  import cksa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PIX_W-1:0]     cfg_data_i,
  // Input pixel items.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     in_red_i,
  input  logic [PIX_W-1:0]     in_green_i,
  input  logic [PIX_W-1:0]     in_blue_i,
  input  logic [PIX_W-1:0]     in_alpha_i,
  input  logic                 last_pixel_i,
  // Result pixel items.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     out_red_o,
  output logic [PIX_W-1:0]     out_green_o,
  output logic [PIX_W-1:0]     out_blue_o,
  output logic [PIX_W-1:0]     out_alpha_o,
  output logic                 end_of_image_o
);

  cfg_t cfg_q, cfg_d;
  logic en;
  pix_t in_pix;
  pix_t res_pix;
  pix_t out_pix;

  // Valid and data at each joint of the chain; joint zero is the front end.
  logic [NUM_CELLS:0] chain_valid;
  div_t               chain_data [NUM_CELLS+1];

  // The register file is written at once; the port never pushes back.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_KEY_RED:   cfg_d.key_red   = cfg_data_i;
        REG_KEY_GREEN: cfg_d.key_green = cfg_data_i;
        REG_KEY_BLUE:  cfg_d.key_blue  = cfg_data_i;
        REG_TOLERANCE: cfg_d.tolerance = cfg_data_i;
        REG_SOFTNESS:  cfg_d.softness  = cfg_data_i;
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_red   <= KEY_RED_RST;
      cfg_q.key_green <= KEY_GREEN_RST;
      cfg_q.key_blue  <= KEY_BLUE_RST;
      cfg_q.tolerance <= TOL_RST;
      cfg_q.softness  <= SOFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The whole chain moves in step; it halts only while the skid stage is full.
  assign in_stall_o = !en;

  assign in_pix.red   = in_red_i;
  assign in_pix.green = in_green_i;
  assign in_pix.blue  = in_blue_i;
  assign in_pix.alpha = in_alpha_i;
  assign in_pix.last  = last_pixel_i;

  cksa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .pix_i   (in_pix),
    .cfg_i   (cfg_q),
    .valid_o (chain_valid[0]),
    .data_o  (chain_data[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cksa_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (chain_valid[i]),
      .data_i    (chain_data[i]),
      .divisor_i (cfg_q.softness),
      .valid_o   (chain_valid[i+1]),
      .data_o    (chain_data[i+1])
    );
  end

  // After the last cell the low word holds the whole quotient.
  always_comb begin
    res_pix = chain_data[NUM_CELLS].pix;
    case (chain_data[NUM_CELLS].mode)
      MODE_CLEAR: res_pix.alpha = '0;
      MODE_RAMP:  res_pix.alpha = chain_data[NUM_CELLS].lowq;
      default:    res_pix.alpha = chain_data[NUM_CELLS].pix.alpha;
    endcase
  end

  cksa_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[NUM_CELLS]),
    .pix_i       (res_pix),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .pix_o       (out_pix),
    .out_stall_i (out_stall_i)
  );

  assign out_red_o      = out_pix.red;
  assign out_green_o    = out_pix.green;
  assign out_blue_o     = out_pix.blue;
  assign out_alpha_o    = out_pix.alpha;
  assign end_of_image_o = out_pix.last;

  // A ramp result never exceeds the alpha it scales.
  a_ramp_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[NUM_CELLS] && (chain_data[NUM_CELLS].mode == MODE_RAMP))
      |-> (chain_data[NUM_CELLS].lowq <= chain_data[NUM_CELLS].pix.alpha))
    else $error("ramp alpha exceeds the input alpha");

  // The final remainder of a ramp item must be below the divisor.
  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chain_valid[NUM_CELLS] && (chain_data[NUM_CELLS].mode == MODE_RAMP))
      |-> (chain_data[NUM_CELLS].rem < cfg_q.softness))
    else $error("division remainder not reduced below softness");

  // Input is held back only while a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

/* dv/chroma_key_soft_alpha_top_test.sv */
// Self-checking testbench for chroma_key_soft_alpha_top: keyed pixel stream with random stalls.
// Depends on cksa_pkg and the chroma_key_soft_alpha_top RTL, with cksa_front, cksa_div_cell and cksa_out below it.

module chroma_key_soft_alpha_top_test
  import cksa_pkg::*;
();

  // A generous tail gives the block time to offer any late result once
  // nothing more is expected.
  localparam int unsigned TAIL_CYCLES  = 24;
  // Longest run of cycles in which no channel moves anything before the run
  // is declared hung. The longest legitimate quiet stretch is the receiver
  // hold-off below, which is far shorter.
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned PHASE_COUNT  = 12;
  localparam int unsigned PHASE_ITEMS  = 152;
  localparam int unsigned HOLD_PHASE   = 5;
  localparam int unsigned HOLD_AT_ITEM = 30;
  localparam logic [PIX_W-1:0] CHAN_MAX = '1;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  // Holds the current key settings, works out the keyed pixel for every item
  // the block takes, and compares the results in order against those pixels.
  class keyed_pixel_checker;
    cfg_t        key_cfg;
    pix_t        keyed_q[$];
    int unsigned mismatches;

    function new();
      key_cfg    = '{KEY_RED_RST, KEY_GREEN_RST, KEY_BLUE_RST, TOL_RST, SOFT_RST};
      mismatches = 0;
    endfunction

    // Writes to indexes above the softness register land nowhere.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] value);
      case (idx)
        REG_KEY_RED:   key_cfg.key_red   = value;
        REG_KEY_GREEN: key_cfg.key_green = value;
        REG_KEY_BLUE:  key_cfg.key_blue  = value;
        REG_TOLERANCE: key_cfg.tolerance = value;
        REG_SOFTNESS:  key_cfg.softness  = value;
        default: ;
      endcase
    endfunction

    function int unsigned chan_gap(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // The distance is the largest per-channel gap to the key colour. At or
    // below tolerance the pixel is cleared; inside the ramp the alpha is
    // scaled by how far past tolerance it lies, rounded to nearest.
    function logic [PIX_W-1:0] keyed_alpha(pix_t p);
      int unsigned key_dist;
      int unsigned tol;
      int unsigned ramp_w;
      int unsigned ramp_pos;
      logic [PIX_W-1:0] res;
      tol      = key_cfg.tolerance;
      ramp_w   = key_cfg.softness;
      key_dist = chan_gap(p.red, key_cfg.key_red);
      if (chan_gap(p.green, key_cfg.key_green) > key_dist)
        key_dist = chan_gap(p.green, key_cfg.key_green);
      if (chan_gap(p.blue, key_cfg.key_blue) > key_dist)
        key_dist = chan_gap(p.blue, key_cfg.key_blue);
      if (key_dist <= tol) begin
        res = '0;
      end else if (ramp_w != 0 && key_dist < tol + ramp_w) begin
        ramp_pos = key_dist - tol;
        res      = PIX_W'((int'(p.alpha) * ramp_pos + ramp_w / 2) / ramp_w);
      end else begin
        res = p.alpha;
      end
      return res;
    endfunction

    function void note_input(pix_t p);
      pix_t keyed;
      keyed       = p;
      keyed.alpha = keyed_alpha(p);
      keyed_q.push_back(keyed);
    endfunction

    function void compare_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_output(pix_t got);
      pix_t want;
      if (keyed_q.size() == 0) begin
        $error("result with no pixel waiting: r %0d g %0d b %0d a %0d eoi %0b",
               got.red, got.green, got.blue, got.alpha, got.last);
        mismatches++;
        return;
      end
      want = keyed_q.pop_front();
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_alpha", want.alpha, got.alpha);
      compare_field("end_of_image", PIX_W'(want.last), PIX_W'(got.last));
    endfunction

    function int unsigned pending();
      return keyed_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [PIX_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     in_red_i;
  logic [PIX_W-1:0]     in_green_i;
  logic [PIX_W-1:0]     in_blue_i;
  logic [PIX_W-1:0]     in_alpha_i;
  logic                 last_pixel_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PIX_W-1:0]     out_red_o;
  logic [PIX_W-1:0]     out_green_o;
  logic [PIX_W-1:0]     out_blue_o;
  logic [PIX_W-1:0]     out_alpha_o;
  logic                 end_of_image_o;

  keyed_pixel_checker board;

  // Receiver behaviour, chosen per phase by the stimulus. A nonzero hold
  // count overrides the pattern and is counted down by the receiver itself.
  rx_mode_e    rx_mode     = RX_FREE;
  int unsigned rx_pct      = 0;
  int unsigned rx_period   = 1;
  int unsigned rx_duty     = 0;
  int unsigned hold_count  = 0;

  // Sender burst shape for the current phase; a zero gap means back to back.
  int unsigned tx_gap_max   = 0;
  int unsigned tx_burst_max = 1;

  chroma_key_soft_alpha_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_red_i       (in_red_i),
    .in_green_i     (in_green_i),
    .in_blue_i      (in_blue_i),
    .in_alpha_i     (in_alpha_i),
    .last_pixel_i   (last_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .out_alpha_o    (out_alpha_o),
    .end_of_image_o (end_of_image_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every result the block hands over is checked at the rising edge, using
  // the values that were stable in the cycle before it.
  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall_i) begin
      board.check_output('{red: out_red_o, green: out_green_o, blue: out_blue_o,
                           alpha: out_alpha_o, last: end_of_image_o});
    end
  end

  // The receiver changes its stall at the falling edge only. During a
  // hold-off it stalls without a break so that the pipeline and the skid
  // register fill up and the input side is pushed back.
  initial begin
    int unsigned rx_tick;
    rx_tick     = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_count != 0) begin
        hold_count--;
        out_stall_i <= 1'b1;
      end else begin
        case (rx_mode)
          RX_RANDOM:   out_stall_i <= ($urandom_range(99, 0) < rx_pct);
          RX_PERIODIC: out_stall_i <= ((rx_tick % rx_period) < rx_duty);
          default:     out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // A hang shows as a long run of cycles in which no channel moves anything.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("chroma_key_soft_alpha_top_test: FAIL");
    $finish;
  end

  // One register write; the valid is left high so that writes can follow
  // each other without a gap, and is lowered by the caller afterwards.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] value);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    board.write_reg(idx, value);
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_key(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b,
                          logic [PIX_W-1:0] tol, logic [PIX_W-1:0] ramp_len);
    cfg_write(REG_KEY_RED, r);
    cfg_write(REG_KEY_GREEN, g);
    cfg_write(REG_KEY_BLUE, b);
    cfg_write(REG_TOLERANCE, tol);
    cfg_write(REG_SOFTNESS, ramp_len);
    cfg_release();
  endtask

  // Writes above the last register must leave the key settings alone.
  task automatic write_spare_regs();
    for (int i = int'(REG_SOFTNESS) + 1; i < (1 << CFG_IDX_W); i++)
      cfg_write(CFG_IDX_W'(i), PIX_W'($urandom_range(255, 0)));
    cfg_release();
  endtask

  // The item is offered from the falling edge and held until the block takes
  // it; the valid stays high so that the next item can follow at once.
  task automatic send_pixel(pix_t p);
    @(negedge clk);
    in_valid_i   <= 1'b1;
    in_red_i     <= p.red;
    in_green_i   <= p.green;
    in_blue_i    <= p.blue;
    in_alpha_i   <= p.alpha;
    last_pixel_i <= p.last;
    do @(posedge clk); while (in_stall_o);
    board.note_input(p);
  endtask

  task automatic sender_gap(int unsigned cycles);
    @(negedge clk);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // The sender stops and waits for every outstanding pixel to come back, so
  // the block is idle before the key settings change.
  task automatic drain();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic pix_t px(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b,
                              logic [PIX_W-1:0] a, logic last);
    return '{red: r, green: g, blue: b, alpha: a, last: last};
  endfunction

  function automatic logic [PIX_W-1:0] near_key(logic [PIX_W-1:0] key, int unsigned span);
    int v;
    v = int'(key) + ($urandom_range(1, 0) ? 1 : -1) * int'($urandom_range(span, 0));
    if (v < 0)
      v = 0;
    if (v > int'(CHAN_MAX))
      v = CHAN_MAX;
    return PIX_W'(v);
  endfunction

  // Most pixels land near the key colour, within reach of the tolerance and
  // the ramp, so that the clear, ramp and pass regions and their boundaries
  // all see plenty of traffic; the rest are anywhere in colour space.
  function automatic pix_t make_pixel();
    pix_t        p;
    int unsigned span;
    span = int'(board.key_cfg.tolerance) + int'(board.key_cfg.softness) + 2;
    if (span > CHAN_MAX)
      span = CHAN_MAX;
    if ($urandom_range(4, 0) == 0) begin
      p.red   = PIX_W'($urandom_range(255, 0));
      p.green = PIX_W'($urandom_range(255, 0));
      p.blue  = PIX_W'($urandom_range(255, 0));
    end else begin
      p.red   = near_key(board.key_cfg.key_red, span);
      p.green = near_key(board.key_cfg.key_green, span);
      p.blue  = near_key(board.key_cfg.key_blue, span);
    end
    case ($urandom_range(7, 0))
      0:       p.alpha = '0;
      1:       p.alpha = CHAN_MAX;
      default: p.alpha = PIX_W'($urandom_range(255, 0));
    endcase
    p.last = ($urandom_range(15, 0) == 0);
    return p;
  endfunction

  // Tolerance and softness levels lean towards the extremes and towards small
  // values, where the ramp is short and rounding matters most.
  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(3, 0))
      0:       return $urandom_range(1, 0) ? CHAN_MAX : '0;
      1:       return PIX_W'($urandom_range(16, 0));
      default: return PIX_W'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_chan();
    return PIX_W'($urandom_range(255, 0));
  endfunction

  task automatic random_phase(int unsigned phase);
    int unsigned burst_left;
    burst_left = 0;
    drain();
    // Idling is set up while the block is empty, away from the falling edge
    // at which the receiver picks up its settings.
    tx_gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(8, 1);
    tx_burst_max = $urandom_range(40, 1);
    rx_mode      = rx_mode_e'((phase + 1) % 3);
    rx_pct       = $urandom_range(70, 10);
    rx_period    = $urandom_range(9, 2);
    rx_duty      = $urandom_range(rx_period - 1, 1);
    case (phase)
      0:       load_key(rand_chan(), rand_chan(), rand_chan(), '0, CHAN_MAX);
      1:       load_key(CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX, CHAN_MAX);
      2:       load_key('0, '0, '0, '0, '0);
      3:       load_key(rand_chan(), rand_chan(), rand_chan(), '0, PIX_W'(1));
      4:       load_key(rand_chan(), rand_chan(), rand_chan(), CHAN_MAX, '0);
      default: load_key(rand_chan(), rand_chan(), rand_chan(), pick_level(), pick_level());
    endcase
    if (phase % 4 == 1)
      write_spare_regs();
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      if (tx_gap_max != 0 && burst_left == 0) begin
        sender_gap($urandom_range(tx_gap_max, 1));
        burst_left = $urandom_range(tx_burst_max, 1);
      end
      // The sender keeps offering pixels while the receiver holds off, so the
      // block fills and has to push back on its input.
      if (phase == HOLD_PHASE && i == HOLD_AT_ITEM)
        hold_count = HOLD_CYCLES;
      send_pixel(make_pixel());
      if (burst_left != 0)
        burst_left--;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_red_i     = '0;
    in_green_i   = '0;
    in_blue_i    = '0;
    in_alpha_i   = '0;
    last_pixel_i = 1'b0;
    board        = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Reset settings first: green key, no tolerance, no ramp.
    rx_mode = RX_RANDOM;
    rx_pct  = 30;
    send_pixel(px(8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
    send_pixel(px(8'd255, 8'd0, 8'd255, 8'd255, 1'b1));
    send_pixel(px(8'd1, 8'd255, 8'd0, 8'h5a, 1'b0));

    // A mid-range key with a ramp: exact key, distance equal to tolerance,
    // just past it, the far end of the ramp, and its upper bound.
    drain();
    load_key(8'd100, 8'd150, 8'd200, 8'd10, 8'd20);
    send_pixel(px(8'd100, 8'd150, 8'd200, 8'd255, 1'b0));
    send_pixel(px(8'd110, 8'd150, 8'd200, 8'd255, 1'b0));
    send_pixel(px(8'd100, 8'd139, 8'd200, 8'd255, 1'b0));
    send_pixel(px(8'd100, 8'd150, 8'd229, 8'd255, 1'b0));
    send_pixel(px(8'd70, 8'd150, 8'd200, 8'd255, 1'b0));
    send_pixel(px(8'd100, 8'd150, 8'd171, 8'd0, 1'b0));
    send_pixel(px(8'd100, 8'd150, 8'd180, 8'd1, 1'b1));

    // Widest possible ramp from a black key.
    drain();
    load_key(8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(px(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(px(8'd254, 8'd0, 8'd0, 8'd255, 1'b0));
    send_pixel(px(8'd1, 8'd0, 8'd0, 8'd255, 1'b0));
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'd170, 1'b0));

    // Full tolerance clears every pixel whatever the ramp.
    drain();
    load_key(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'd255, 1'b0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 8'haa, 1'b1));

    // A two-step ramp, where rounding to nearest decides the results inside it.
    drain();
    load_key(8'd128, 8'd128, 8'd128, 8'd0, 8'd2);
    send_pixel(px(8'd129, 8'd128, 8'd128, 8'd255, 1'b0));
    send_pixel(px(8'd128, 8'd128, 8'd127, 8'd254, 1'b0));
    send_pixel(px(8'd131, 8'd128, 8'd128, 8'd99, 1'b0));

    // Tolerance plus softness well past eight bits must not wrap, and writes
    // to the unused register indexes must not disturb the settings.
    drain();
    load_key(8'd0, 8'd0, 8'd0, 8'd254, 8'd255);
    send_pixel(px(8'd255, 8'd0, 8'd0, 8'd200, 1'b0));
    send_pixel(px(8'd0, 8'd0, 8'd254, 8'd200, 1'b0));
    drain();
    write_spare_regs();
    send_pixel(px(8'd255, 8'd0, 8'd0, 8'd200, 1'b1));

    // Random part: each phase has its own key settings and idling pattern.
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++)
      random_phase(phase);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("chroma_key_soft_alpha_top_test: PASS");
    else
      $display("chroma_key_soft_alpha_top_test: FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/cksa_pkg.sv
rtl/cksa_front.sv
rtl/cksa_div_cell.sv
rtl/cksa_out.sv
rtl/chroma_key_soft_alpha_top.sv
dv/chroma_key_soft_alpha_top_test.sv
